// ===== rtl/core/quaternion_to_yaw_pitch_roll_assert.svh =====
// Assertion macros used by the top level of the quaternion to yaw, pitch and roll RTL.
`ifndef QUATERNION_TO_YAW_PITCH_ROLL_ASSERT_SVH
`define QUATERNION_TO_YAW_PITCH_ROLL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QYP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QYP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/qyp_pkg.sv =====
// Shared widths, constants and the arctangent table of the attitude datapath.
`default_nettype none
package qyp_pkg;

	localparam int Q_W        = 16;
	localparam int ANGLE_W    = 16;
	localparam int GRAV_W     = 20;
	localparam int PROD_W     = 34;
	localparam int SUM_W      = 38;
	localparam int ROOT_W     = 19;
	localparam int TILT_W     = 15;
	localparam int Z_W        = 34;
	localparam int NORM_STEPS = 5;
	localparam int GRAV_LAT   = 4;
	localparam int YAW_OP_LAT = 2;

	localparam logic [TILT_W-1:0] TILT_RESET = 15'd819;
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

	// Arctangent of 2^-idx in Q30 radians.
	function automatic logic [30:0] atan_q30(input int idx);
		logic [30:0] v;
		case (idx)
			0: v = 31'd843314857;
			1: v = 31'd497837829;
			2: v = 31'd263043837;
			3: v = 31'd133525159;
			4: v = 31'd67021687;
			5: v = 31'd33543516;
			6: v = 31'd16775851;
			7: v = 31'd8388437;
			8: v = 31'd4194283;
			9: v = 31'd2097149;
			10: v = 31'd1048576;
			11: v = 31'd524288;
			12: v = 31'd262144;
			13: v = 31'd131072;
			14: v = 31'd65536;
			15: v = 31'd32768;
			16: v = 31'd16384;
			17: v = 31'd8192;
			18: v = 31'd4096;
			19: v = 31'd2048;
			20: v = 31'd1024;
			21: v = 31'd512;
			22: v = 31'd256;
			23: v = 31'd128;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/qyp_delay.sv =====
// Enabled shift line that keeps side data in step with the pipeline.
`default_nettype none
module qyp_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] tap_s [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) begin
				tap_s[i] <= '0;
			end
		end else if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < D; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[D-1];
endmodule
`default_nettype wire

// ===== rtl/core/qyp_gravity.sv =====
// Quaternion products, gravity vector, yaw operands and tilt threshold tests.
`default_nettype none
module qyp_gravity (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [qyp_pkg::Q_W-1:0]      q0,
	input  logic signed [qyp_pkg::Q_W-1:0]      q1,
	input  logic signed [qyp_pkg::Q_W-1:0]      q2,
	input  logic signed [qyp_pkg::Q_W-1:0]      q3,
	input  logic [qyp_pkg::TILT_W-1:0]          tilt,
	output logic signed [qyp_pkg::PROD_W-1:0]   yaw_num,
	output logic signed [qyp_pkg::PROD_W-1:0]   yaw_den,
	output logic signed [qyp_pkg::GRAV_W-1:0]   gx,
	output logic signed [qyp_pkg::GRAV_W-1:0]   gy,
	output logic [qyp_pkg::SUM_W-1:0]           sum_yz,
	output logic [qyp_pkg::SUM_W-1:0]           sum_xz,
	output logic                                small_yz,
	output logic                                small_xz,
	output logic signed [qyp_pkg::Q_W-1:0]      gx_sat,
	output logic signed [qyp_pkg::Q_W-1:0]      gy_sat,
	output logic signed [qyp_pkg::Q_W-1:0]      gz_sat
);
	import qyp_pkg::*;

	localparam logic signed [PROD_W-1:0] HALF    = 34'sd8192;
	localparam logic signed [PROD_W-1:0] YD_BIAS = 34'sd268435456;

	function automatic logic signed [Q_W-1:0] sat16(input logic signed [GRAV_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > 20'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -20'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

	logic signed [31:0] p00_s1, p11_s1, p22_s1, p33_s1, p01_s1;
	logic signed [31:0] p23_s1, p13_s1, p02_s1, p12_s1, p03_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= q0 * q0;
			p11_s1 <= q1 * q1;
			p22_s1 <= q2 * q2;
			p33_s1 <= q3 * q3;
			p01_s1 <= q0 * q1;
			p23_s1 <= q2 * q3;
			p13_s1 <= q1 * q3;
			p02_s1 <= q0 * q2;
			p12_s1 <= q1 * q2;
			p03_s1 <= q0 * q3;
		end
	end

	logic signed [PROD_W-1:0] gx_full, gy_full, gz_full;

	assign gx_full = ((PROD_W'(p13_s1) - PROD_W'(p02_s1)) <<< 1) + HALF;
	assign gy_full = ((PROD_W'(p01_s1) + PROD_W'(p23_s1)) <<< 1) + HALF;
	assign gz_full = PROD_W'(p00_s1) - PROD_W'(p11_s1) - PROD_W'(p22_s1)
		+ PROD_W'(p33_s1) + HALF;

	logic signed [GRAV_W-1:0] gx_s2, gy_s2, gz_s2;
	logic signed [PROD_W-1:0] yn_s2, yd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s2 <= gx_full[PROD_W-1:14];
			gy_s2 <= gy_full[PROD_W-1:14];
			gz_s2 <= gz_full[PROD_W-1:14];
			yn_s2 <= (PROD_W'(p12_s1) <<< 1) - (PROD_W'(p03_s1) <<< 1);
			yd_s2 <= (PROD_W'(p00_s1) <<< 1) + (PROD_W'(p11_s1) <<< 1) - YD_BIAS;
		end
	end

	assign yaw_num = yn_s2;
	assign yaw_den = yd_s2;

	logic signed [2*GRAV_W-1:0] gxx, gyy, gzz;
	logic [SUM_W-1:0] gxx_s3, gyy_s3, gzz_s3;
	logic signed [GRAV_W-1:0] gx_s3, gy_s3, gz_s3;
	logic [2*TILT_W-1:0] thr_sq_q;

	assign gxx = gx_s2 * gx_s2;
	assign gyy = gy_s2 * gy_s2;
	assign gzz = gz_s2 * gz_s2;

	// The user must change the threshold only while the pipeline is empty; the block does not enforce it.
	always_ff @(posedge clk) begin
		thr_sq_q <= tilt * tilt;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gxx_s3 <= gxx[SUM_W-1:0];
			gyy_s3 <= gyy[SUM_W-1:0];
			gzz_s3 <= gzz[SUM_W-1:0];
			gx_s3  <= gx_s2;
			gy_s3  <= gy_s2;
			gz_s3  <= gz_s2;
		end
	end

	logic [SUM_W-1:0] syz, sxz;
	logic [SUM_W-1:0] syz_s4, sxz_s4;
	logic small_yz_s4, small_xz_s4;
	logic signed [GRAV_W-1:0] gx_s4, gy_s4;
	logic signed [Q_W-1:0] gxs_s4, gys_s4, gzs_s4;

	assign syz = gyy_s3 + gzz_s3;
	assign sxz = gxx_s3 + gzz_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			syz_s4      <= syz;
			sxz_s4      <= sxz;
			small_yz_s4 <= syz < SUM_W'(thr_sq_q);
			small_xz_s4 <= sxz < SUM_W'(thr_sq_q);
			gx_s4       <= gx_s3;
			gy_s4       <= gy_s3;
			gxs_s4      <= sat16(gx_s3);
			gys_s4      <= sat16(gy_s3);
			gzs_s4      <= sat16(gz_s3);
		end
	end

	assign gx       = gx_s4;
	assign gy       = gy_s4;
	assign sum_yz   = syz_s4;
	assign sum_xz   = sxz_s4;
	assign small_yz = small_yz_s4;
	assign small_xz = small_xz_s4;
	assign gx_sat   = gxs_s4;
	assign gy_sat   = gys_s4;
	assign gz_sat   = gzs_s4;
endmodule
`default_nettype wire

// ===== rtl/core/qyp_sqrt.sv =====
// Pipelined floor square root, one root bit per stage.
`default_nettype none
module qyp_sqrt #(
	parameter int RW = 19
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] radicand,
	output logic [RW-1:0]   root
);
	localparam int TW = 2 * RW + 2;

	logic [TW-1:0] rem_c  [RW];
	logic [RW-1:0] root_c [RW];
	logic [TW-1:0] rem_s  [1:RW-1];
	logic [RW-1:0] root_s [1:RW];

	for (genvar k = 0; k < RW; k++) begin : g_bit
		localparam int B = RW - 1 - k;
		logic [TW-1:0] trial;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_c[k]  = TW'(radicand);
			assign root_c[k] = '0;
		end else begin : g_next
			assign rem_c[k]  = rem_s[k];
			assign root_c[k] = root_s[k];
		end

		// Growth of the square when this root bit is set.
		assign trial = (TW'(root_c[k]) << (B + 1)) + (TW'(1) << (2 * B));
		assign take  = rem_c[k] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k+1] <= take ? (root_c[k] | (RW'(1) << B)) : root_c[k];
			end
		end

		if (k < RW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= take ? (rem_c[k] - trial) : rem_c[k];
				end
			end
		end
	end

	assign root = root_s[RW];
endmodule
`default_nettype wire

// ===== rtl/core/qyp_cordic.sv =====
// Pipelined vectoring CORDIC: range normalization, quadrant fix, rotations, rounding.
`default_nettype none
module qyp_cordic #(
	parameter int IW     = 20,
	parameter int SW     = 16,
	parameter int STAGES = 16
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [IW-1:0]                x_in,
	input  logic signed [IW-1:0]                y_in,
	output logic signed [qyp_pkg::ANGLE_W-1:0]  angle
);
	import qyp_pkg::*;

	localparam int VW = (IW > SW) ? IW : SW;
	localparam int CW = SW + 2;
	localparam logic [VW-1:0] HI = VW'(1) << (SW - 2);
	localparam logic signed [Z_W-1:0] ZRND    = 34'sd65536;
	localparam logic signed [Z_W-1:0] ANG_MAX = 34'sd32767;
	localparam logic signed [Z_W-1:0] ANG_MIN = -34'sd32768;

	function automatic logic [VW-1:0] magv(input logic signed [VW-1:0] v);
		return (v < 0) ? VW'(-v) : VW'(v);
	endfunction

	function automatic logic [VW-1:0] maxv(input logic [VW-1:0] a, input logic [VW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	logic signed [VW-1:0] nx_s [NORM_STEPS+1];
	logic signed [VW-1:0] ny_s [NORM_STEPS+1];
	logic                 need_s [NORM_STEPS+1];
	logic                 zero_s [NORM_STEPS+1];

	logic signed [VW-1:0] xe, ye;
	logic [VW-1:0]        me;

	assign xe = VW'(x_in);
	assign ye = VW'(y_in);
	assign me = maxv(magv(xe), magv(ye));

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s[0]   <= xe;
			ny_s[0]   <= ye;
			need_s[0] <= me >= HI;
			zero_s[0] <= me == '0;
		end
	end

	// A large vector is shifted down by the largest amount that still leaves it
	// out of range, plus one more at the end; a small one is shifted up as far
	// as it stays in range. Each stage tries one power of two.
	for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
		localparam int S = 1 << (NORM_STEPS - 1 - j);
		logic signed [VW-1:0] rx, ry;
		logic [VW-1:0]        mr, mc;

		assign rx = nx_s[j] >>> S;
		assign ry = ny_s[j] >>> S;
		assign mr = maxv(magv(rx), magv(ry));
		assign mc = maxv(magv(nx_s[j]), magv(ny_s[j]));

		always_ff @(posedge clk) begin
			if (en) begin
				need_s[j+1] <= need_s[j];
				zero_s[j+1] <= zero_s[j];
				if (need_s[j] && (mr >= HI)) begin
					nx_s[j+1] <= rx;
					ny_s[j+1] <= ry;
				end else if (!need_s[j] && !zero_s[j] && (mc < (HI >> S))) begin
					nx_s[j+1] <= nx_s[j] <<< S;
					ny_s[j+1] <= ny_s[j] <<< S;
				end else begin
					nx_s[j+1] <= nx_s[j];
					ny_s[j+1] <= ny_s[j];
				end
			end
		end
	end

	logic signed [CW-1:0]  px, py;
	logic signed [CW-1:0]  cx_s [STAGES+1];
	logic signed [CW-1:0]  cy_s [STAGES+1];
	logic signed [Z_W-1:0] cz_s [STAGES+1];
	logic                  czero_s [STAGES+1];

	assign px = CW'(need_s[NORM_STEPS] ? (nx_s[NORM_STEPS] >>> 1) : nx_s[NORM_STEPS]);
	assign py = CW'(need_s[NORM_STEPS] ? (ny_s[NORM_STEPS] >>> 1) : ny_s[NORM_STEPS]);

	// Vectors in the left half plane are turned by a quarter turn first.
	always_ff @(posedge clk) begin
		if (en) begin
			czero_s[0] <= zero_s[NORM_STEPS];
			if (px < 0) begin
				if (py >= 0) begin
					cx_s[0] <= py;
					cy_s[0] <= -px;
					cz_s[0] <= HALF_PI_Q30;
				end else begin
					cx_s[0] <= -py;
					cy_s[0] <= px;
					cz_s[0] <= -HALF_PI_Q30;
				end
			end else begin
				cx_s[0] <= px;
				cy_s[0] <= py;
				cz_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		logic signed [CW-1:0]  dx, dy;
		logic signed [Z_W-1:0] at;

		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;
		assign at = Z_W'(atan_q30(i));

		always_ff @(posedge clk) begin
			if (en) begin
				czero_s[i+1] <= czero_s[i];
				if (cy_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] + dx;
					cy_s[i+1] <= cy_s[i] - dy;
					cz_s[i+1] <= cz_s[i] + at;
				end else begin
					cx_s[i+1] <= cx_s[i] - dx;
					cy_s[i+1] <= cy_s[i] + dy;
					cz_s[i+1] <= cz_s[i] - at;
				end
			end
		end
	end

	logic signed [Z_W-1:0]     zr;
	logic signed [ANGLE_W-1:0] angle_q;

	assign zr = (cz_s[STAGES] + ZRND) >>> 17;

	always_ff @(posedge clk) begin
		if (en) begin
			if (czero_s[STAGES]) begin
				angle_q <= '0;
			end else if (zr > ANG_MAX) begin
				angle_q <= 16'sh7fff;
			end else if (zr < ANG_MIN) begin
				angle_q <= 16'sh8000;
			end else begin
				angle_q <= zr[ANGLE_W-1:0];
			end
		end
	end

	assign angle = angle_q;
endmodule
`default_nettype wire

// ===== rtl/core/quaternion_to_yaw_pitch_roll.sv =====
// Top level: quaternion in, yaw, pitch, roll and gravity vector out.
//
// One beat on the s_ side carries a quaternion, four signed Q2.14 components.
// One beat on the m_ side carries yaw, pitch and roll in signed Q3.13 radians
// and the gravity vector in signed Q2.14, saturated to 16 bits.
// cfg_we writes tilt_threshold (unsigned Q1.14); pitch or roll reads zero when
// the magnitude of its companion components falls below it. Write it only
// while no beat is in flight.
// The pipeline runs through the products and sums, the bit-per-stage square
// root, then the CORDIC (input, five normalization steps, quadrant fix,
// rotations, rounding). A new beat is taken every cycle while the output
// is not stalled.
// Reset clears all valid bits and loads the threshold with 819 (0.05).
// When the receiver stalls, the whole pipeline holds and s_tready drops in the
// same cycle; nothing is lost or repeated.
`default_nettype none
`include "quaternion_to_yaw_pitch_roll_assert.svh"
module quaternion_to_yaw_pitch_roll #(
	parameter int CORDIC_STAGES = 16,
	parameter int SAMPLE_WIDTH  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// quat_c0, quat_c1, quat_c2, quat_c3
	input  logic [63:0]                    s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// yaw_angle, pitch_angle, roll_angle, gravity_x, gravity_y, gravity_z
	output logic [95:0]                    m_tdata,
	input  logic                           cfg_we,
	input  logic [qyp_pkg::TILT_W-1:0]     cfg_data
);
	import qyp_pkg::*;

	localparam int CORDIC_LAT = CORDIC_STAGES + NORM_STEPS + 3;
	localparam int TOTAL_LAT  = GRAV_LAT + ROOT_W + CORDIC_LAT;
	localparam int YAW_PAD    = TOTAL_LAT - YAW_OP_LAT - CORDIC_LAT;
	localparam int SIDE_W     = 3 * Q_W + 2;
	localparam logic signed [ANGLE_W-1:0] TILT_LIM = 16'sd12900;

	logic pipe_en;
	logic [TILT_W-1:0] tilt_q;

	assign pipe_en  = !m_tvalid || m_tready;
	assign s_tready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_q <= TILT_RESET;
		end else if (cfg_we) begin
			tilt_q <= cfg_data;
		end
	end

	logic signed [PROD_W-1:0] yaw_num, yaw_den;
	logic signed [GRAV_W-1:0] gx, gy, gx_d, gy_d;
	logic [SUM_W-1:0] sum_yz, sum_xz;
	logic small_yz, small_xz;
	logic signed [Q_W-1:0] gx_sat, gy_sat, gz_sat;

	qyp_gravity u_gravity (
		.clk      (clk),
		.en       (pipe_en),
		.q0       ($signed(s_tdata[15:0])),
		.q1       ($signed(s_tdata[31:16])),
		.q2       ($signed(s_tdata[47:32])),
		.q3       ($signed(s_tdata[63:48])),
		.tilt     (tilt_q),
		.yaw_num  (yaw_num),
		.yaw_den  (yaw_den),
		.gx       (gx),
		.gy       (gy),
		.sum_yz   (sum_yz),
		.sum_xz   (sum_xz),
		.small_yz (small_yz),
		.small_xz (small_xz),
		.gx_sat   (gx_sat),
		.gy_sat   (gy_sat),
		.gz_sat   (gz_sat)
	);

	logic [ROOT_W-1:0] root_yz, root_xz;

	qyp_sqrt #(.RW(ROOT_W)) u_sqrt_yz (
		.clk      (clk),
		.en       (pipe_en),
		.radicand (sum_yz),
		.root     (root_yz)
	);

	qyp_sqrt #(.RW(ROOT_W)) u_sqrt_xz (
		.clk      (clk),
		.en       (pipe_en),
		.radicand (sum_xz),
		.root     (root_xz)
	);

	qyp_delay #(.W(2 * GRAV_W), .D(ROOT_W)) u_grav_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (pipe_en),
		.d      ({gy, gx}),
		.q      ({gy_d, gx_d})
	);

	logic signed [ANGLE_W-1:0] yaw_c, yaw_d, pitch_c, roll_c;

	qyp_cordic #(.IW(PROD_W), .SW(SAMPLE_WIDTH), .STAGES(CORDIC_STAGES)) u_cordic_yaw (
		.clk   (clk),
		.en    (pipe_en),
		.x_in  (yaw_den),
		.y_in  (yaw_num),
		.angle (yaw_c)
	);

	qyp_cordic #(.IW(GRAV_W), .SW(SAMPLE_WIDTH), .STAGES(CORDIC_STAGES)) u_cordic_pitch (
		.clk   (clk),
		.en    (pipe_en),
		.x_in  ($signed({1'b0, root_yz})),
		.y_in  (gx_d),
		.angle (pitch_c)
	);

	qyp_cordic #(.IW(GRAV_W), .SW(SAMPLE_WIDTH), .STAGES(CORDIC_STAGES)) u_cordic_roll (
		.clk   (clk),
		.en    (pipe_en),
		.x_in  ($signed({1'b0, root_xz})),
		.y_in  (gy_d),
		.angle (roll_c)
	);

	qyp_delay #(.W(ANGLE_W), .D(YAW_PAD)) u_yaw_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (pipe_en),
		.d      (yaw_c),
		.q      (yaw_d)
	);

	logic [SIDE_W-1:0] side_d;
	logic small_yz_d, small_xz_d;
	logic signed [Q_W-1:0] gxs_d, gys_d, gzs_d;

	qyp_delay #(.W(SIDE_W), .D(ROOT_W + CORDIC_LAT)) u_side_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (pipe_en),
		.d      ({small_xz, small_yz, gz_sat, gy_sat, gx_sat}),
		.q      (side_d)
	);

	assign {small_xz_d, small_yz_d, gzs_d, gys_d, gxs_d} = side_d;

	qyp_delay #(.W(1), .D(TOTAL_LAT)) u_valid_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (pipe_en),
		.d      (s_tvalid),
		.q      (m_tvalid)
	);

	logic signed [ANGLE_W-1:0] pitch_out, roll_out;

	assign pitch_out = small_yz_d ? '0 : pitch_c;
	assign roll_out  = small_xz_d ? '0 : roll_c;

	assign m_tdata = {gzs_d, gys_d, gxs_d, roll_out, pitch_out, yaw_d};

	// Pitch and roll come from a vector with a non-negative x, so they stay
	// within a quarter turn.
	`QYP_ASSERT_IMP(a_pitch_range, clk, arst_n, m_tvalid, (pitch_out <= TILT_LIM) && (pitch_out >= -TILT_LIM), "pitch beyond a quarter turn")
	`QYP_ASSERT_IMP(a_roll_range, clk, arst_n, m_tvalid, (roll_out <= TILT_LIM) && (roll_out >= -TILT_LIM), "roll beyond a quarter turn")
	`QYP_ASSERT_IMP(a_backpressure, clk, arst_n, m_tvalid && !m_tready, !s_tready, "input taken while the output is stalled")
	`QYP_ASSERT_NXT(a_flags_hold, clk, arst_n, m_tvalid && !m_tready, $stable(small_yz_d) && $stable(small_xz_d), "tilt flags moved during a stall")
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the quaternion to yaw, pitch, roll and gravity block.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CORDIC_STAGES = 16;
	localparam int SAMPLE_WIDTH  = 16;
	localparam int RANDOM_ITEMS  = 1950;
	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = CORDIC_STAGES + 40;

	typedef struct packed {
		logic signed [15:0] c3;
		logic signed [15:0] c2;
		logic signed [15:0] c1;
		logic signed [15:0] c0;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] gz;
		logic signed [15:0] gy;
		logic signed [15:0] gx;
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
	} attitude_t;

	typedef struct {
		quat_t q;
		bit    grav_known;
		logic signed [15:0] gx, gy, gz;
		bit    tilt_zero;
	} stim_row_t;

	localparam longint ATAN_Q30 [24] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128
	};
	localparam longint HALF_PI = 64'sd1686629713;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [63:0]               s_tdata;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [95:0]               m_tdata;
	logic                      cfg_we;
	logic [qyp_pkg::TILT_W-1:0] cfg_data;

	quaternion_to_yaw_pitch_roll #(
		.CORDIC_STAGES(CORDIC_STAGES),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data)
	);

	attitude_t attitude_q[$];
	longint    tilt_thr;
	int        errors;
	int        beats_in;
	int        beats_out;
	int        idle_cycles;
	bit        send_quiet;
	bit        recv_quiet;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint floor_sqrt(longint n);
		longint unsigned r, b, u;
		u = n;
		r = 0;
		b = 64'd1 << 62;
		while (b > u) b = b >> 2;
		while (b != 0) begin
			if (u >= r + b) begin
				u = u - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	// Vectoring CORDIC, Q3.13 result.
	function automatic longint atan2_q13(longint y, longint x);
		longint z, t, dx, dy, m, hi, lo;
		int i;
		hi = 64'sd1 << (SAMPLE_WIDTH - 2);
		lo = 64'sd1 << (SAMPLE_WIDTH - 3);
		z = 0;
		m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
		if (m == 0) return 0;
		while (m >= hi) begin
			x = x >>> 1;
			y = y >>> 1;
			m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
		end
		while (m < lo && m != 0) begin
			x = x * 2;
			y = y * 2;
			m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = HALF_PI;
			end else begin
				x = -y; y = t; z = -HALF_PI;
			end
		end
		for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_Q30[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_Q30[i];
			end
		end
		return sat16((z + (64'sd1 << 16)) >>> 17);
	endfunction

	function automatic attitude_t predict_attitude(quat_t q);
		longint q0, q1, q2, q3, gx, gy, gz, yn, yd, syz, sxz, thr2;
		attitude_t a;
		q0 = q.c0; q1 = q.c1; q2 = q.c2; q3 = q.c3;
		thr2 = tilt_thr * tilt_thr;
		gx = (2 * (q1 * q3 - q0 * q2) + 8192) >>> 14;
		gy = (2 * (q0 * q1 + q2 * q3) + 8192) >>> 14;
		gz = (q0 * q0 - q1 * q1 - q2 * q2 + q3 * q3 + 8192) >>> 14;
		yn = 2 * q1 * q2 - 2 * q0 * q3;
		yd = 2 * q0 * q0 + 2 * q1 * q1 - (64'sd1 << 28);
		syz = gy * gy + gz * gz;
		sxz = gx * gx + gz * gz;
		a.yaw   = 16'(atan2_q13(yn, yd));
		a.pitch = (syz < thr2) ? 16'sd0 : 16'(atan2_q13(gx, floor_sqrt(syz)));
		a.roll  = (sxz < thr2) ? 16'sd0 : 16'(atan2_q13(gy, floor_sqrt(sxz)));
		a.gx = 16'(sat16(gx));
		a.gy = 16'(sat16(gy));
		a.gz = 16'(sat16(gz));
		return a;
	endfunction

	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_quat(quat_t q, attitude_t expected, bit use_expected);
		int gap;
		gap = pick_gap(send_quiet);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			s_tdata  = {$urandom, $urandom};
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = q;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		attitude_q.push_back(use_expected ? expected : predict_attitude(q));
		beats_in++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (attitude_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_tilt(longint value);
		wait_idle();
		cfg_we   = 1'b1;
		cfg_data = value[14:0];
		@(negedge clk);
		cfg_we   = 1'b0;
		tilt_thr = value;
	endtask

	function automatic quat_t random_quat();
		real a[4];
		real n;
		quat_t q;
		if ($urandom_range(0, 9) < 4) begin
			q = {$urandom, $urandom};
			return q;
		end
		n = 0.0;
		foreach (a[i]) begin
			a[i] = ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
			n += a[i] * a[i];
		end
		// Mostly unit quaternions; occasionally one scaled to 1.3 times the unit length.
		if (n < 1.0e-4) return quat_t'({16'sd0, 16'sd0, 16'sd0, 16'sd16384});
		n = $sqrt(n) / (16384.0 * (($urandom_range(0, 9) == 0) ? 1.3 : 1.0));
		q.c0 = 16'($rtoi(a[0] / n));
		q.c1 = 16'($rtoi(a[1] / n));
		q.c2 = 16'($rtoi(a[2] / n));
		q.c3 = 16'($rtoi(a[3] / n));
		return q;
	endfunction

	stim_row_t directed[$] = '{
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, 16'sd0, 16'sd0, 16'sd0, 1},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 0, 0, 0, 0, 0},
		'{'{16'sd0, 16'sd0, 16'sd0, -16'sd16384}, 0, 0, 0, 0, 0},
		'{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 0, 0, 0, 0, 0},
		'{'{16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 0, 0, 0, 0, 0},
		'{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 0, 0, 0, 0, 0},
		'{'{16'sd0, 16'sd0, 16'sd11585, 16'sd11585}, 0, 0, 0, 0, 0},
		'{'{16'sd0, 16'sd11585, 16'sd0, 16'sd11585}, 0, 0, 0, 0, 0},
		'{'{16'sd11585, 16'sd0, 16'sd0, 16'sd11585}, 0, 0, 0, 0, 0},
		'{'{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192}, 0, 0, 0, 0, 0},
		'{'{-16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192}, 0, 0, 0, 0, 0},
		'{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 0, 0, 0, 0, 0},
		'{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
			1, 16'sd0, 16'sd32767, 16'sd0, 0},
		'{'{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767}, 0, 0, 0, 0, 0},
		'{'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768}, 0, 0, 0, 0, 0},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd1}, 1, 16'sd0, 16'sd0, 16'sd0, 1},
		'{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1, 16'sd0, 16'sd0, 16'sd0, 1},
		'{'{16'sd0, 16'sd0, 16'sd600, 16'sd16373}, 0, 0, 0, 0, 0},
		'{'{16'sd0, 16'sd12000, 16'sd0, 16'sd11150}, 0, 0, 0, 0, 0}
	};

	// Output side: random backpressure and the scoreboard.
	initial begin : receiver
		int stall;
		stall = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
				stall = pick_gap(recv_quiet);
			end
		end
	end

	always @(posedge clk) begin : scoreboard
		attitude_t want;
		if (arst_n && m_tvalid && m_tready) begin
			beats_out++;
			if (attitude_q.size() == 0) begin
				$error("result beat with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				want = attitude_q.pop_front();
				for (int f = 0; f < 6; f++) begin
					if (m_tdata[16*f +: 16] !== want[16*f +: 16]) begin
						$error("field %0d (%s): expected %0d, got %0d", f,
							f == 0 ? "yaw_angle" : f == 1 ? "pitch_angle" :
							f == 2 ? "roll_angle" : f == 3 ? "gravity_x" :
							f == 4 ? "gravity_y" : "gravity_z",
							$signed(want[16*f +: 16]), $signed(m_tdata[16*f +: 16]));
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
				$display("tb failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		longint thr_plan[5];
		attitude_t a;
		int per_phase;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		errors = 0;
		beats_in = 0;
		beats_out = 0;
		idle_cycles = 0;
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
		tilt_thr = 819;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			a = predict_attitude(directed[i].q);
			if (directed[i].grav_known) begin
				a.gx = directed[i].gx;
				a.gy = directed[i].gy;
				a.gz = directed[i].gz;
			end
			if (directed[i].tilt_zero) begin
				a.pitch = '0;
				a.roll = '0;
			end
			send_quat(directed[i].q, a, 1'b1);
		end

		thr_plan = '{0, 32767, $urandom_range(0, 32767), 16384, 819};
		per_phase = RANDOM_ITEMS / 5;
		foreach (thr_plan[p]) begin
			write_tilt(thr_plan[p]);
			// With a zero threshold, the zero vector must still read zero.
			if (thr_plan[p] == 0) begin
				repeat (3) send_quat('0, a, 1'b0);
			end
			for (int k = 0; k < per_phase; k++) begin
				if (k % 100 == 0) begin
					send_quiet = ($urandom_range(0, 3) == 0);
					recv_quiet = ($urandom_range(0, 3) == 0);
				end
				send_quat(random_quat(), a, 1'b0);
			end
		end

		wait_idle();
		$display("sent %0d quaternions, checked %0d results over five threshold settings",
			beats_in, beats_out);
		$display("thresholds included 0 and 32767, with random stalls on both sides");
		if (errors == 0 && attitude_q.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/qyp_pkg.sv
rtl/core/qyp_delay.sv
rtl/core/qyp_gravity.sv
rtl/core/qyp_sqrt.sv
rtl/core/qyp_cordic.sv
rtl/core/quaternion_to_yaw_pitch_roll.sv
tb/sv/tb.sv
